// File: src/fsq_pkg.sv
// fsq_pkg: shared types, constants and fp16 helper functions for the quantiser
// used by fsq_div, fsq_mul and fp16_simulated_quantizer_core
package fsq_pkg;

	localparam logic [15:0] QNAN16 = 16'h7E00;
	localparam logic [14:0] INF15 = 15'h7C00;
	localparam int DIV_QBITS = 13;

	typedef enum logic [1:0] {
		CFG_ABS_MAX = 2'd0,
		CFG_DOWNSCALE = 2'd1,
		CFG_DROP_MASK = 2'd2,
		CFG_ROUNDING_MODE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [15:0] random_bits;
		logic last_in;
	} in_t;

	typedef struct packed {
		logic [15:0] quantised;
		logic last_out;
	} out_t;

	// fields that ride alongside the arithmetic
	typedef struct packed {
		logic [15:0] random_bits;
		logic last;
	} side_t;

	typedef struct packed {
		logic [10:0] sig;
		logic signed [6:0] expo;
	} norm_t;

	// finite nonzero magnitude to 1.f significand and unbiased exponent
	function automatic norm_t norm16(input logic [14:0] h);
		norm_t r;
		logic [3:0] p;
		p = 4'd0;
		if (h[14:10] != 5'd0) begin
			r.sig = {1'b1, h[9:0]};
			r.expo = $signed({2'b00, h[14:10]}) - 7'sd15;
		end else begin
			for (int i = 0; i < 10; i++) begin
				if (h[i]) begin
					p = 4'(i);
				end
			end
			r.sig = {1'b0, h[9:0]} << (4'd10 - p);
			r.expo = $signed({3'b000, p}) - 7'sd24;
		end
		return r;
	endfunction

	// round sig (leading one at bit 23) times 2^e to fp16, nearest even
	function automatic logic [15:0] pack16(input logic sgn, input logic [23:0] sig,
			input logic signed [7:0] e, input logic sticky);
		logic signed [8:0] biased;
		logic signed [8:0] shamt;
		logic [4:0] field;
		logic [4:0] sh;
		logic [47:0] ext;
		logic [23:0] s;
		logic st;
		logic rnd;
		logic [14:0] bits;
		biased = $signed({e[7], e}) + 9'sd15;
		shamt = 9'sd1 - biased;
		if (biased >= 9'sd1) begin
			field = biased[4:0];
			s = sig;
			st = sticky;
		end else begin
			sh = (shamt > 9'sd25) ? 5'd25 : shamt[4:0];
			ext = {sig, 24'd0} >> sh;
			s = ext[47:24];
			st = sticky | (|ext[23:0]);
			field = 5'd0;
		end
		rnd = s[12] & (st | (|s[11:0]) | s[13]);
		bits = {field, s[22:13]} + {14'd0, rnd};
		if (biased > 9'sd30 || bits >= INF15) begin
			bits = INF15;
		end
		return {sgn, bits};
	endfunction

endpackage

// File: src/fsq_div.sv
// fsq_div: pipelined fp16 divider, restoring, one quotient bit per stage
// depends on fsq_pkg
module fsq_div (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [15:0] a,
	input logic [14:0] b,
	input fsq_pkg::side_t side_in,
	output logic out_valid,
	output logic [15:0] quot,
	output fsq_pkg::side_t side_out
);
	import fsq_pkg::*;

	logic v_st [0:DIV_QBITS];
	logic spec_st [0:DIV_QBITS];
	logic [15:0] sval_st [0:DIV_QBITS];
	logic sgn_st [0:DIV_QBITS];
	logic signed [7:0] exp_st [0:DIV_QBITS];
	logic [11:0] rem_st [0:DIV_QBITS];
	logic [10:0] mb_st [0:DIV_QBITS];
	logic [12:0] q_st [0:DIV_QBITS];
	side_t side_st [0:DIV_QBITS];

	logic a_nan, b_nan, az, bz, ai, bi, nan_c;
	norm_t na, nb;
	logic [15:0] sval;

	always_comb begin
		a_nan = a[14:0] > INF15;
		b_nan = b > INF15;
		az = a[14:0] == 15'd0;
		bz = b == 15'd0;
		ai = a[14:0] == INF15;
		bi = b == INF15;
		nan_c = a_nan | b_nan | (az & bz) | (ai & bi);
		na = norm16(a[14:0]);
		nb = norm16(b);
		if (nan_c) begin
			sval = QNAN16;
		end else if (ai | bz) begin
			sval = {a[15], INF15};
		end else begin
			sval = {a[15], 15'd0};
		end
	end

	// operand classification and normalisation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_st[0] <= 1'b0;
		end else if (en) begin
			v_st[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_st[0] <= nan_c | ai | bz | az | bi;
			sval_st[0] <= sval;
			sgn_st[0] <= a[15];
			exp_st[0] <= $signed({na.expo[6], na.expo}) - $signed({nb.expo[6], nb.expo});
			rem_st[0] <= {1'b0, na.sig};
			mb_st[0] <= nb.sig;
			q_st[0] <= 13'd0;
			side_st[0] <= side_in;
		end
	end

	for (genvar i = 1; i <= DIV_QBITS; i++) begin : g_step
		logic ge;
		logic [11:0] diff;
		assign ge = rem_st[i-1] >= {1'b0, mb_st[i-1]};
		assign diff = ge ? rem_st[i-1] - {1'b0, mb_st[i-1]} : rem_st[i-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[i] <= 1'b0;
			end else if (en) begin
				v_st[i] <= v_st[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				spec_st[i] <= spec_st[i-1];
				sval_st[i] <= sval_st[i-1];
				sgn_st[i] <= sgn_st[i-1];
				exp_st[i] <= exp_st[i-1];
				rem_st[i] <= {diff[10:0], 1'b0};
				mb_st[i] <= mb_st[i-1];
				q_st[i] <= {q_st[i-1][11:0], ge};
				side_st[i] <= side_st[i-1];
			end
		end
	end

	logic [12:0] qf;
	logic [23:0] sig;
	logic signed [7:0] ef;

	always_comb begin
		qf = q_st[DIV_QBITS];
		if (qf[12]) begin
			sig = {qf, 11'd0};
			ef = exp_st[DIV_QBITS];
		end else begin
			sig = {qf[11:0], 12'd0};
			ef = exp_st[DIV_QBITS] - 8'sd1;
		end
	end

	// rounding and packing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_st[DIV_QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot <= spec_st[DIV_QBITS] ? sval_st[DIV_QBITS]
				: pack16(sgn_st[DIV_QBITS], sig, ef, rem_st[DIV_QBITS] != 12'd0);
			side_out <= side_st[DIV_QBITS];
		end
	end

endmodule

// File: src/fsq_mul.sv
// fsq_mul: three-stage fp16 multiplier, round to nearest even
// depends on fsq_pkg
module fsq_mul (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [15:0] a,
	input logic [14:0] b,
	input logic last_in,
	output logic out_valid,
	output fsq_pkg::out_t out_data
);
	import fsq_pkg::*;

	logic a_nan, b_nan, az, bz, ai, bi, nan_c;
	norm_t na, nb;
	logic [15:0] sval;

	always_comb begin
		a_nan = a[14:0] > INF15;
		b_nan = b > INF15;
		az = a[14:0] == 15'd0;
		bz = b == 15'd0;
		ai = a[14:0] == INF15;
		bi = b == INF15;
		nan_c = a_nan | b_nan | (ai & bz) | (bi & az);
		na = norm16(a[14:0]);
		nb = norm16(b);
		if (nan_c) begin
			sval = QNAN16;
		end else if (ai | bi) begin
			sval = {a[15], INF15};
		end else begin
			sval = {a[15], 15'd0};
		end
	end

	logic v_s1, v_s2;
	logic spec_s1, spec_s2;
	logic [15:0] sval_s1, sval_s2;
	logic sgn_s1, sgn_s2;
	logic signed [7:0] exp_s1, exp_s2;
	logic [10:0] sa_s1, sb_s1;
	logic [21:0] prod_s2;
	logic last_s1, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	logic [23:0] sig;
	logic signed [7:0] ef;

	always_comb begin
		if (prod_s2[21]) begin
			sig = {prod_s2, 2'd0};
			ef = exp_s2 + 8'sd1;
		end else begin
			sig = {prod_s2[20:0], 3'd0};
			ef = exp_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= nan_c | ai | bi | az | bz;
			sval_s1 <= sval;
			sgn_s1 <= a[15];
			exp_s1 <= $signed({na.expo[6], na.expo}) + $signed({nb.expo[6], nb.expo});
			sa_s1 <= na.sig;
			sb_s1 <= nb.sig;
			last_s1 <= last_in;

			spec_s2 <= spec_s1;
			sval_s2 <= sval_s1;
			sgn_s2 <= sgn_s1;
			exp_s2 <= exp_s1;
			prod_s2 <= sa_s1 * sb_s1;
			last_s2 <= last_s1;

			out_data.quantised <= spec_s2 ? sval_s2 : pack16(sgn_s2, sig, ef, 1'b0);
			out_data.last_out <= last_s2;
		end
	end

endmodule

// File: src/fp16_simulated_quantizer_core.sv
// fp16_simulated_quantizer_core: clamp, fp16 divide, offset and mask, fp16 multiply
// depends on fsq_pkg, fsq_div and fsq_mul
//
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    in_data   (fsq_pkg::in_t)
// out       output     out_valid / out_stall  out_data  (fsq_pkg::out_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction enters per cycle unless halted; the stages are clamp, the divider
// (normalise, 13 quotient steps, round/pack), offset/mask, three multiplier stages
// the whole pipeline advances together; it halts only while a result sits
// on the output and out_stall is high, so nothing is lost or repeated
// reset clears all valid bits and loads the default register values
// cfg writes are always taken (cfg_ready is tied high)
module fp16_simulated_quantizer_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input fsq_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output fsq_pkg::out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	import fsq_pkg::*;

	// configuration registers
	logic [14:0] abs_max_q;
	logic [14:0] downscale_q;
	logic [15:0] drop_mask_q;
	logic rounding_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_max_q <= 15'h7BFF;
			downscale_q <= 15'h3C00;
			drop_mask_q <= 16'h0000;
			rounding_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ABS_MAX: abs_max_q <= cfg_data[14:0];
				CFG_DOWNSCALE: downscale_q <= cfg_data[14:0];
				CFG_DROP_MASK: drop_mask_q <= cfg_data;
				CFG_ROUNDING_MODE: rounding_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// global advance: hold everything only when the output is full and stalled
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: clamp to +/- abs_max, nan sample or nan limit passes untouched
	logic v_s1;
	logic [15:0] x_s1;
	side_t side_s1;
	logic do_clamp;

	assign do_clamp = (in_data.sample[14:0] <= INF15) && (abs_max_q <= INF15)
		&& (in_data.sample[14:0] > abs_max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= do_clamp ? {in_data.sample[15], abs_max_q} : in_data.sample;
			side_s1.random_bits <= in_data.random_bits;
			side_s1.last <= in_data.last_in;
		end
	end

	// divide by downscale
	logic div_valid;
	logic [15:0] div_q;
	side_t div_side;

	fsq_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s1),
		.a(x_s1),
		.b(downscale_q),
		.side_in(side_s1),
		.out_valid(div_valid),
		.quot(div_q),
		.side_out(div_side)
	);

	// stage 2: add rounding offset to the raw pattern (wraps), then clear masked bits
	logic v_s2;
	logic [15:0] x_s2;
	logic last_s2;
	logic [15:0] offset;

	assign offset = rounding_mode_q ? (div_side.random_bits & drop_mask_q)
		: {1'b0, drop_mask_q[15:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= (div_q + offset) & ~drop_mask_q;
			last_s2 <= div_side.last;
		end
	end

	// multiply back by downscale, output register is its last stage
	fsq_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s2),
		.a(x_s2),
		.b(downscale_q),
		.last_in(last_s2),
		.out_valid(out_valid),
		.out_data(out_data)
	);

	// a stalled result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	// the rounding stage freezes while input is held off
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s2) && $stable(x_s2))
		else $error("pipeline moved during stall");

	// the only nan ever produced is the canonical quiet nan
	a_qnan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.quantised[14:0] > INF15) |-> out_data.quantised == QNAN16)
		else $error("non-canonical nan on output");

endmodule

// File: sim/fp16_simulated_quantizer_core_tb.sv
// fp16_simulated_quantizer_core_tb: self-checking bench for the fp16 quantiser core
// predicts each result with its own fp16 clamp, divide, offset/mask and multiply
// depends on fsq_pkg and fp16_simulated_quantizer_core
module fp16_simulated_quantizer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fsq_pkg::*;

	localparam int LATENCY = 20;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [15:0] QUIET_NAN = 16'h7E00;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	// predictor copy of the registers
	logic [14:0] clamp_mag;
	logic [14:0] scale;
	logic [15:0] mask;
	logic stochastic;

	out_t quantised_q[$];
	int mismatches;
	int results_seen;
	int idle_cycles;
	bit hold_off;
	bit sender_bursty;

	fp16_simulated_quantizer_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_nan(logic [15:0] h);
		return h[14:0] > 15'h7C00;
	endfunction

	// magnitude as integer significand and power of two
	function automatic void unpack_half(logic [15:0] h, output longint unsigned m,
			output int e);
		if (h[14:10] == 5'd0) begin
			m = h[9:0];
			e = -24;
		end else begin
			m = {1'b1, h[9:0]};
			e = int'(h[14:10]) - 25;
		end
	endfunction

	// round m * 2^e (plus sticky fraction) to fp16, nearest even
	function automatic logic [15:0] round_half(logic sgn, longint unsigned m, int e,
			bit sticky);
		int p;
		int big_e;
		int t;
		int sh;
		longint unsigned q;
		longint unsigned rem;
		longint unsigned half;
		longint unsigned bits;
		p = 63;
		while (p > 0 && m[p] == 1'b0) p--;
		big_e = p + e;
		if (big_e > 15) return {sgn, 15'h7C00};
		if (big_e < -25) return {sgn, 15'h0};
		t = (big_e - 10 > -24) ? big_e - 10 : -24;
		sh = t - e;
		if (sh <= 0) begin
			q = m << (-sh);
		end else begin
			rem = m & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			q = m >> sh;
			if (rem > half || (rem == half && (sticky || q[0]))) q++;
		end
		if (t == -24 && big_e < -14) bits = q;
		else bits = (longint'(big_e + 15) << 10) + q - 1024;
		if (bits >= 64'h7C00) return {sgn, 15'h7C00};
		return {sgn, bits[14:0]};
	endfunction

	function automatic logic [15:0] half_divide(logic [15:0] a, logic [15:0] b);
		logic sgn;
		bit az, bz, ai, bi;
		longint unsigned ma, mb;
		int ea, eb;
		sgn = a[15] ^ b[15];
		az = a[14:0] == 0;
		bz = b[14:0] == 0;
		ai = a[14:0] == 15'h7C00;
		bi = b[14:0] == 15'h7C00;
		if (is_nan(a) || is_nan(b) || (az && bz) || (ai && bi)) return QUIET_NAN;
		if (ai || bz) return {sgn, 15'h7C00};
		if (az || bi) return {sgn, 15'h0};
		unpack_half(a, ma, ea);
		unpack_half(b, mb, eb);
		return round_half(sgn, (ma << 40) / mb, ea - 40 - eb, ((ma << 40) % mb) != 0);
	endfunction

	function automatic logic [15:0] half_multiply(logic [15:0] a, logic [15:0] b);
		logic sgn;
		bit az, bz, ai, bi;
		longint unsigned ma, mb;
		int ea, eb;
		sgn = a[15] ^ b[15];
		az = a[14:0] == 0;
		bz = b[14:0] == 0;
		ai = a[14:0] == 15'h7C00;
		bi = b[14:0] == 15'h7C00;
		if (is_nan(a) || is_nan(b) || (ai && bz) || (bi && az)) return QUIET_NAN;
		if (ai || bi) return {sgn, 15'h7C00};
		if (az || bz) return {sgn, 15'h0};
		unpack_half(a, ma, ea);
		unpack_half(b, mb, eb);
		return round_half(sgn, ma * mb, ea + eb, 1'b0);
	endfunction

	function automatic out_t quantise(in_t item);
		logic [15:0] x;
		logic [15:0] offset;
		int k;
		int lim;
		out_t r;
		x = item.sample;
		// clamp skipped when either side is NaN
		if (!is_nan(x) && !is_nan({1'b0, clamp_mag})) begin
			k = x[15] ? -int'(x[14:0]) : int'(x[14:0]);
			lim = int'(clamp_mag);
			if (k > lim) x = {1'b0, clamp_mag};
			else if (k < -lim) x = {1'b1, clamp_mag};
		end
		x = half_divide(x, {1'b0, scale});
		offset = stochastic ? (item.random_bits & mask) : (mask >> 1);
		x = (x + offset) & ~mask; // wraps at 16 bits
		r.quantised = half_multiply(x, {1'b0, scale});
		r.last_out = item.last_in;
		return r;
	endfunction

	// one cfg transaction; only issued while the pipeline is empty
	task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ABS_MAX: clamp_mag = value[14:0];
			CFG_DOWNSCALE: scale = value[14:0];
			CFG_DROP_MASK: mask = value;
			CFG_ROUNDING_MODE: stochastic = value[0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [15:0] amax, logic [15:0] ds, logic [15:0] m, logic mode);
		write_reg(CFG_ABS_MAX, amax);
		write_reg(CFG_DOWNSCALE, ds);
		write_reg(CFG_DROP_MASK, m);
		write_reg(CFG_ROUNDING_MODE, {15'd0, mode});
		cfg_valid <= 1'b0;
	endtask

	// offer one transaction and hold it until accepted
	task automatic send_sample(logic [15:0] s, logic [15:0] rnd, logic lst);
		in_t item;
		item.sample = s;
		item.random_bits = rnd;
		item.last_in = lst;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		quantised_q.push_back(quantise(item));
		// burst gaps
		if (sender_bursty && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (quantised_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] random_sample();
		case ($urandom_range(0, 7))
			0: return {$urandom_range(0, 1) == 1, 5'h1F, 10'($urandom)}; // inf/NaN
			1: return {$urandom_range(0, 1) == 1, 5'h00, 10'($urandom)}; // subnormal
			default: return 16'($urandom);
		endcase
	endfunction

	// extremes and special cases at reset settings and two fixed ones
	task automatic test_directed();
		logic [15:0] picks[12];
		picks = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFFFF,
			16'h7BFF, 16'hFBFF, 16'h0001, 16'h83FF, 16'h3C00, 16'hBC00};
		foreach (picks[i]) send_sample(picks[i], 16'hFFFF, i[0]);
		drain();
		// zero clamp, zero scale, full mask carry, NaN clamp
		set_all(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
		foreach (picks[i]) if (i < 6) send_sample(picks[i], 16'h0000, 1'b1);
		drain();
		set_all(16'h7FFF, 16'h3C00, 16'h03FF, 1'b1);
		foreach (picks[i]) if (i < 6) send_sample(picks[i], ~picks[i], 1'b0);
		drain();
	endtask

	task automatic test_random_settings();
		logic [15:0] masks[4];
		for (int phase = 0; phase < 10; phase++) begin
			masks = '{16'h0000, 16'hFFFF, 16'((1 << $urandom_range(1, 12)) - 1), 16'($urandom)};
			set_all(phase == 0 ? 16'h7BFF : 16'($urandom_range(0, 32767)),
				phase == 1 ? 16'h7BFF : 16'($urandom_range(0, 32767)),
				masks[phase % 4], 1'(phase % 2));
			repeat (100) send_sample(random_sample(), 16'($urandom), 1'($urandom));
			drain();
		end
	endtask

	// receiver holds off long enough for the pipeline to back up
	task automatic test_backpressure();
		set_all(16'h7BFF, 16'h4000, 16'h001F, 1'b1);
		hold_off = 1'b1;
		fork
			begin
				repeat (3 * LATENCY) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (200) send_sample(random_sample(), 16'($urandom), 1'($urandom));
		join
		drain();
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if (($urandom & 32'h3F) < 8) out_stall <= 1'b0; // stall-free stretch
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	// result checker
	always @(posedge clk) begin
		out_t exp_q;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (quantised_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_data);
			end else begin
				exp_q = quantised_q.pop_front();
				if (out_data.quantised !== exp_q.quantised ||
						out_data.last_out !== exp_q.last_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: quantised exp %h got %h, last exp %b got %b",
							exp_q.quantised, out_data.quantised,
							exp_q.last_out, out_data.last_out);
				end
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fp16_simulated_quantizer_core_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		results_seen = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		sender_bursty = 1'b1;
		clamp_mag = 15'h7BFF;
		scale = 15'h3C00;
		mask = 16'h0000;
		stochastic = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_backpressure();
		$display("covered directed fp16 extremes, ten register settings, both rounding modes");
		$display("and a long output stall; %0d results compared", results_seen);
		if (mismatches == 0 && quantised_q.size() == 0)
			$display("fp16_simulated_quantizer_core_tb: clean");
		else
			$display("fp16_simulated_quantizer_core_tb: errors");
		$finish;
	end

endmodule
